[rtl/acdr_pkg.sv]
// ----------------------------------------------------------------------------
// acdr_pkg
// shared widths, reset values, register codes and types of the duty regulator
// ----------------------------------------------------------------------------
package acdr_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int DUTY_W     = 10;
	localparam int SUM_W      = 16;
	localparam int CNT_W      = 5;
	localparam int THR_W      = 4;
	localparam int WINDOW_DEF = 61;

	// entries of each queue; also the number of results allowed in flight
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SAMPLE_W-1:0] SET_POINT_RST = SAMPLE_W'(700);
	localparam logic [THR_W-1:0]    STEP_THR_RST  = THR_W'(10);
	localparam logic [DUTY_W-1:0]   DUTY_MAX      = DUTY_W'(1023);
	localparam logic [DUTY_W-1:0]   DUTY_MAX_M1   = DUTY_W'(1022);

	typedef enum logic [0:0] {
		REG_SET_POINT = 1'b0,
		REG_STEP_THR  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] set_point;
		logic [THR_W-1:0]    step_threshold;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average_level;
		logic [DUTY_W-1:0]   duty_cycle;
	} res_t;

endpackage

[rtl/acdr_queue.sv]
// ----------------------------------------------------------------------------
// acdr_queue
// small first-in first-out queue with valid/ready on both sides
// ----------------------------------------------------------------------------
module acdr_queue #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/acdr_front.sv]
// ----------------------------------------------------------------------------
// acdr_front
// input stage: takes sample transfers and hands them to the work queue
// ----------------------------------------------------------------------------
module acdr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [acdr_pkg::SAMPLE_W-1:0] push_data
);
	import acdr_pkg::*;

	logic                held_q;
	logic [SAMPLE_W-1:0] sample_q;

	// the stage frees up in the same cycle its sample moves on
	assign s_tready   = !held_q || push_ready;
	assign push_valid = held_q;
	assign push_data  = sample_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (s_tready) begin
			held_q <= s_tvalid;
		end
	end

endmodule

[rtl/acdr_back.sv]
// ----------------------------------------------------------------------------
// acdr_back
// sample ring, running sum, divide by window and bang-bang duty update
// ----------------------------------------------------------------------------
module acdr_back #(
	parameter int WINDOW = acdr_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acdr_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [acdr_pkg::SAMPLE_W-1:0] q_data,
	input  logic                          credit_ok,
	output logic                          res_valid,
	output acdr_pkg::res_t                res
);
	import acdr_pkg::*;

	localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
	localparam longint DIV_MULT = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int MULT_W    = SUM_W + 2;
	localparam int PROD_W    = SUM_W + MULT_W;
	localparam int AVG_W     = PROD_W - DIV_SHIFT;
	localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW - 1);
	localparam logic [MULT_W-1:0] MULT_C   = MULT_W'(DIV_MULT);

	logic [SAMPLE_W-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]   ring_vld_q;
	logic [POS_W-1:0]    pos_q;
	logic [SUM_W-1:0]    sum_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic [DUTY_W-1:0]   duty_q;

	logic                vld_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [SAMPLE_W-1:0] old_s1;
	logic                old_vld_s1;
	logic                vld_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic                vld_s3;
	logic [PROD_W-1:0]   prod_s3;
	logic                res_valid_q;
	res_t                res_q;

	logic                issue;
	logic [SUM_W-1:0]    old_eff;
	logic [SUM_W-1:0]    sum_nx;
	logic [AVG_W-1:0]    avg_full;
	logic [SAMPLE_W-1:0] avg;
	logic signed [CNT_W:0] cnt_ext;
	logic signed [CNT_W:0] cnt_mv;
	logic signed [CNT_W:0] thr_s;
	logic signed [CNT_W-1:0] cnt_nx;
	logic [DUTY_W-1:0]   duty_nx;

	// one item in the read stage at a time: the ring write lands before the next read
	assign q_ready = !vld_s1 && credit_ok;
	assign issue   = q_valid && q_ready;

	assign old_eff = old_vld_s1 ? SUM_W'(old_s1) : '0;
	assign sum_nx  = sum_q - old_eff + SUM_W'(sample_s1);

	assign avg_full = prod_s3[PROD_W-1:DIV_SHIFT];
	assign avg      = (avg_full > AVG_W'(DUTY_MAX)) ? DUTY_MAX : avg_full[SAMPLE_W-1:0];

	always_comb begin
		cnt_ext = {cnt_q[CNT_W-1], cnt_q};
		thr_s   = signed'((CNT_W+1)'(cfg.step_threshold));
		cnt_mv  = cnt_ext;
		cnt_nx  = cnt_q;
		duty_nx = duty_q;
		if (avg > cfg.set_point) begin
			cnt_mv = cnt_ext - (CNT_W+1)'(1);
			if (cnt_mv < -thr_s) begin
				cnt_nx = '0;
				if (duty_q != '0) begin
					duty_nx = duty_q - DUTY_W'(1);
				end
			end else begin
				cnt_nx = cnt_mv[CNT_W-1:0];
			end
		end else if (avg < cfg.set_point) begin
			cnt_mv = cnt_ext + (CNT_W+1)'(1);
			if (cnt_mv > thr_s) begin
				cnt_nx = '0;
				if (duty_q <= DUTY_MAX_M1) begin
					duty_nx = duty_q + DUTY_W'(1);
				end
			end else begin
				cnt_nx = cnt_mv[CNT_W-1:0];
			end
		end
	end

	// ring memory: registered read at issue, write-back in the following cycle
	always_ff @(posedge clk) begin
		if (issue) begin
			old_s1 <= ring_mem[pos_q];
		end
		if (vld_s1) begin
			ring_mem[pos_s1] <= sample_s1;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (issue) begin
			sample_s1  <= q_data;
			pos_s1     <= pos_q;
			old_vld_s1 <= ring_vld_q[pos_q];
		end
		if (vld_s1) begin
			sum_s2 <= sum_nx;
		end
		if (vld_s2) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(MULT_C);
		end
		if (vld_s3) begin
			res_q.duty_cycle    <= duty_nx;
			res_q.average_level <= avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q  <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			duty_q      <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			res_valid_q <= vld_s3;
			if (issue) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
			end
			if (vld_s1) begin
				sum_q              <= sum_nx;
				ring_vld_q[pos_s1] <= 1'b1;
			end
			if (vld_s3) begin
				cnt_q  <= cnt_nx;
				duty_q <= duty_nx;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/averaged_current_duty_regulator.sv]
// ----------------------------------------------------------------------------
// averaged_current_duty_regulator
// moving-average bang-bang duty regulator for a current-sense loop
// ----------------------------------------------------------------------------
// Each input transfer carries one 10-bit current-sense sample. The block keeps
// the last WINDOW samples in a ring memory together with their running sum,
// takes the truncated average (sum divided by WINDOW through a reciprocal
// multiply), and moves a signed step counter toward the set point: down when
// the average is above it, up when below. Once the counter goes past the step
// threshold the duty cycle steps by one (held within 0..1023) and the counter
// clears. Every sample gives exactly one output transfer with the new duty
// cycle and the average. A new sample may not enter the ring read before the
// previous one is written back, set by the ring memory port: a sample's old
// ring entry is read, then replaced in the cycle after, before the following
// sample may read. On its way to the output a sample passes the input stage,
// work queue, ring read, sum, multiply, regulation and result queue registers.
// Input and output are decoupled by queues; an output stall holds back the
// input only once the results in flight fill the result queue; up to four
// results may wait on the output. The ring comes out of
// reset reading as zero through per-entry valid bits, so no clearing pass is
// needed and samples are taken from the first cycle after reset. Registers:
// set_point at byte address 0, step_threshold at byte address 4; write them
// only while no sample is in flight.
// ----------------------------------------------------------------------------
module averaged_current_duty_regulator #(
	parameter int WINDOW = acdr_pkg::WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sense_sample
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [9:0] duty_cycle, [19:10] average_level
);
	import acdr_pkg::*;

	localparam int INF_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [INF_W-1:0] INF_MAX = INF_W'(QUEUE_DEPTH);

	cfg_t                cfg_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	logic                fq_valid;
	logic                fq_ready;
	logic [SAMPLE_W-1:0] fq_data;
	logic                bq_valid;
	logic                bq_ready;
	logic [SAMPLE_W-1:0] bq_data;

	logic                res_valid;
	res_t                res;
	logic                out_push_ready;
	res_t                out_data;

	logic [INF_W-1:0]    inflight_q;
	logic                credit_ok;
	logic                issue;
	logic                deliver;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_SET_POINT: prdata = 32'(cfg_q.set_point);
			REG_STEP_THR:  prdata = 32'(cfg_q.step_threshold);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_point      <= SET_POINT_RST;
			cfg_q.step_threshold <= STEP_THR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SET_POINT: cfg_q.set_point      <= pwdata[SAMPLE_W-1:0];
				REG_STEP_THR:  cfg_q.step_threshold <= pwdata[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	// ---------------- front: input stage and work queue ----------------
	acdr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data)
	);

	acdr_queue #(
		.WIDTH (SAMPLE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_work_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	// ---------------- back: averaging and regulation ----------------
	acdr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (bq_valid),
		.q_ready   (bq_ready),
		.q_data    (bq_data),
		.credit_ok (credit_ok),
		.res_valid (res_valid),
		.res       (res)
	);

	// results in flight never outnumber result queue entries, so a push always fits
	assign issue     = bq_valid && bq_ready;
	assign deliver   = m_tvalid && m_tready;
	assign credit_ok = (inflight_q < INF_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (issue && !deliver) begin
			inflight_q <= inflight_q + INF_W'(1);
		end else if (deliver && !issue) begin
			inflight_q <= inflight_q - INF_W'(1);
		end
	end

	acdr_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (out_push_ready),
		.push_data  (res),
		.pop_valid  (m_tvalid),
		.pop_ready  (m_tready),
		.pop_data   (out_data)
	);

	assign m_tdata = {4'b0000, out_data.average_level, out_data.duty_cycle};

	// ---------------- assertions ----------------
	a_result_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_push_ready)
		else $error("result queue full when a result was produced");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INF_MAX)
		else $error("more results in flight than result queue entries");

	a_issue_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> !issue)
		else $error("two samples issued in back-to-back cycles to the ring");

	a_deliver_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		deliver |-> (inflight_q != '0))
		else $error("output transfer with no result in flight");

endmodule
